>>> sv/ewma_power_stats_table_unit_defines.svh
// Assertion macros for the EWMA power statistics table.
// Included by the top level; no other dependencies.
`ifndef EWMA_POWER_STATS_TABLE_UNIT_DEFINES_SVH
`define EWMA_POWER_STATS_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EWPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EWPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EWPS_ASSERT_IMP(label, ante, cons, msg)
`define EWPS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> sv/ewps_pkg.sv
// Shared types and constants for the EWMA power statistics table.
// No dependencies.
package ewps_pkg;

    localparam int NUM_NODES_DEF     = 64;
    localparam int NUM_SUB_BANDS_DEF = 16;
    localparam int QDEPTH            = 2;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    typedef enum logic [2:0] {
        MODE_ALL      = 3'd0,
        MODE_CARRIER  = 3'd1,
        MODE_INTERF   = 3'd2,
        MODE_PATHLOSS = 3'd3,
        MODE_READ     = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CFG_WEIGHT_LOCAL  = 3'd0,
        CFG_WEIGHT_REMOTE = 3'd1,
        CFG_DEF_CARRIER   = 3'd2,
        CFG_DEF_INTERF    = 3'd3,
        CFG_DEF_PATHLOSS  = 3'd4,
        CFG_DEF_C_DEV     = 3'd5,
        CFG_DEF_I_DEV     = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_SQ,
        ST_MUL,
        ST_SUM,
        ST_MSQ,
        ST_DIFF,
        ST_ROOT,
        ST_DONE
    } state_t;

    // one flag per quantity: carrier, interference, pathloss
    typedef struct packed {
        logic c;
        logic i;
        logic p;
    } upd_t;

    typedef struct packed {
        upd_t        upd;
        logic        in_range;
        logic [16:0] weight;
        logic [31:0] carrier;
        logic [31:0] interf;
        logic [47:0] pathloss;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> sv/ewps_isqrt.sv
// Bit-serial floor square root, 64-bit operand, one result bit per cycle.
// Depends on nothing.
module ewps_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] val_reg, val_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    always_comb
    begin
        rem_sh    = {rem_reg[32:0], val_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> sv/ewps_front.sv
// Front end: accepts items, decodes mode, key and weight, queues them.
// Depends on ewps_pkg.
module ewps_front
#(
    parameter int NUM_NODES     = ewps_pkg::NUM_NODES_DEF,
    parameter int NUM_SUB_BANDS = ewps_pkg::NUM_SUB_BANDS_DEF,
    localparam int DEPTH = NUM_NODES * NUM_SUB_BANDS,
    localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [5:0]            node_id,
    input  logic [3:0]            sub_band,
    input  logic                  origin_remote,
    input  logic [31:0]           carrier_power,
    input  logic [31:0]           interference_power,
    input  logic [47:0]           pathloss_factor,
    input  logic [16:0]           weight_local,
    input  logic [16:0]           weight_remote,
    input  logic                  hold,
    input  logic                  pop,
    output ewps_pkg::item_t       head_item,
    output logic [KW-1:0]         head_key,
    output ewps_pkg::q_stat_t     stat
);

    localparam int PW = (ewps_pkg::QDEPTH > 1) ? $clog2(ewps_pkg::QDEPTH) : 1;

    ewps_pkg::item_t item_q [ewps_pkg::QDEPTH];
    logic [KW-1:0]   key_q  [ewps_pkg::QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    ewps_pkg::item_t new_item;
    logic [KW-1:0]   new_key;
    logic [16:0]     w_raw;
    logic            push;

    always_comb
    begin
        new_item.upd = '0;
        unique case (ewps_pkg::mode_t'(mode))
            ewps_pkg::MODE_ALL:      new_item.upd = '{c: 1'b1, i: 1'b1, p: 1'b1};
            ewps_pkg::MODE_CARRIER:  new_item.upd.c = 1'b1;
            ewps_pkg::MODE_INTERF:   new_item.upd.i = 1'b1;
            ewps_pkg::MODE_PATHLOSS: new_item.upd.p = 1'b1;
            default:                 new_item.upd = '0;
        endcase
        new_item.in_range = (int'(node_id) < NUM_NODES) && (int'(sub_band) < NUM_SUB_BANDS);
        w_raw = origin_remote ? weight_remote : weight_local;
        // anything with bit 16 set is at or above one
        new_item.weight   = w_raw[16] ? ewps_pkg::WEIGHT_ONE : w_raw;
        new_item.carrier  = carrier_power;
        new_item.interf   = interference_power;
        new_item.pathloss = pathloss_factor;
        new_key = KW'(int'(node_id) * NUM_SUB_BANDS + int'(sub_band));
    end

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == (PW+1)'(ewps_pkg::QDEPTH));
    assign in_ready   = !stat.full && !hold;
    assign push       = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(ewps_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(ewps_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_q[wr_ptr_reg] <= new_item;
            key_q[wr_ptr_reg]  <= new_key;
        end
    end

    assign head_item = item_q[rd_ptr_reg];
    assign head_key  = key_q[rd_ptr_reg];

endmodule

>>> sv/ewps_back.sv
// Back end: table memories, read-modify-write blend, deviation roots, result register.
// Depends on ewps_pkg and ewps_isqrt.
module ewps_back
#(
    parameter int NUM_NODES     = ewps_pkg::NUM_NODES_DEF,
    parameter int NUM_SUB_BANDS = ewps_pkg::NUM_SUB_BANDS_DEF,
    localparam int DEPTH = NUM_NODES * NUM_SUB_BANDS,
    localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ewps_pkg::q_stat_t stat,
    input  ewps_pkg::item_t   head_item,
    input  logic [KW-1:0]     head_key,
    output logic              pop,
    output logic              hold,
    input  logic [31:0]       def_carrier,
    input  logic [31:0]       def_interf,
    input  logic [47:0]       def_pathloss,
    input  logic [31:0]       def_c_dev,
    input  logic [31:0]       def_i_dev,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       avg_carrier,
    output logic [31:0]       avg_interference,
    output logic [47:0]       avg_pathloss,
    output logic [31:0]       carrier_dev,
    output logic [31:0]       interference_dev,
    output logic              carrier_found,
    output logic              interference_found,
    output logic              pathloss_found
);

    ewps_pkg::state_t state_reg, state_next;
    logic [KW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             out_valid_reg, out_valid_next;

    // table memories
    logic [31:0]     cm_mem  [DEPTH];
    logic [63:0]     csq_mem [DEPTH];
    logic [31:0]     im_mem  [DEPTH];
    logic [63:0]     isq_mem [DEPTH];
    logic [47:0]     pm_mem  [DEPTH];
    ewps_pkg::upd_t  vm_mem  [DEPTH];

    logic [31:0]     cm_rd, im_rd;
    logic [63:0]     csq_rd, isq_rd;
    logic [47:0]     pm_rd;
    ewps_pkg::upd_t  vm_rd;

    ewps_pkg::item_t item_reg;
    logic [KW-1:0]   key_reg;
    ewps_pkg::upd_t  v_old_reg, v_new_reg;
    logic [16:0]     cw;

    logic [63:0] csq_reg, isq_reg;
    logic [47:0] cma_reg, cmb_reg, ima_reg, imb_reg;
    logic [63:0] pma_reg, pmb_reg;
    logic [47:0] cla_reg, clb_reg, cha_reg, chb_reg;
    logic [47:0] ila_reg, ilb_reg, iha_reg, ihb_reg;

    logic [31:0] c_new, i_new;
    logic [63:0] csq_new, isq_new;
    logic [47:0] p_new;
    ewps_pkg::upd_t v_new;
    logic [31:0] c_new_reg, i_new_reg;
    logic [63:0] csq_new_reg, isq_new_reg;
    logic [47:0] p_new_reg;
    logic [63:0] cmsq_reg, imsq_reg;
    logic [63:0] c_diff, i_diff;
    logic        root_start, c_busy, i_busy;
    logic [31:0] c_root, i_root;
    logic        mem_we, load_out;

    assign cw = ewps_pkg::WEIGHT_ONE - item_reg.weight;

    // blend: (old*(1-w) + new*w) >> 16 where a mean is already valid, else the new value; square means in 32-bit halves
    always_comb
    begin
        c_new   = cm_rd;
        csq_new = csq_rd;
        i_new   = im_rd;
        isq_new = isq_rd;
        p_new   = pm_rd;
        if (item_reg.upd.c)
        begin
            if (v_old_reg.c)
            begin
                c_new   = 32'((49'(cma_reg) + 49'(cmb_reg)) >> 16);
                csq_new = (64'(49'(cha_reg) + 49'(chb_reg)) << 16)
                        + 64'((49'(cla_reg) + 49'(clb_reg)) >> 16);
            end
            else
            begin
                c_new   = item_reg.carrier;
                csq_new = csq_reg;
            end
        end
        if (item_reg.upd.i)
        begin
            if (v_old_reg.i)
            begin
                i_new   = 32'((49'(ima_reg) + 49'(imb_reg)) >> 16);
                isq_new = (64'(49'(iha_reg) + 49'(ihb_reg)) << 16)
                        + 64'((49'(ila_reg) + 49'(ilb_reg)) >> 16);
            end
            else
            begin
                i_new   = item_reg.interf;
                isq_new = isq_reg;
            end
        end
        if (item_reg.upd.p)
            p_new = v_old_reg.p ? 48'((pma_reg + pmb_reg) >> 16) : item_reg.pathloss;
        v_new = item_reg.in_range ? (v_old_reg | item_reg.upd) : '0;
    end

    assign c_diff = (csq_new_reg > cmsq_reg) ? (csq_new_reg - cmsq_reg) : '0;
    assign i_diff = (isq_new_reg > imsq_reg) ? (isq_new_reg - imsq_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        root_start     = 1'b0;
        mem_we         = 1'b0;
        load_out       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ewps_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == KW'(DEPTH - 1))
                    state_next = ewps_pkg::ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ewps_pkg::ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = ewps_pkg::ST_RD;
                end
            end
            ewps_pkg::ST_RD:   state_next = ewps_pkg::ST_SQ;
            ewps_pkg::ST_SQ:   state_next = ewps_pkg::ST_MUL;
            ewps_pkg::ST_MUL:  state_next = ewps_pkg::ST_SUM;
            ewps_pkg::ST_SUM:
            begin
                mem_we     = item_reg.in_range;
                state_next = ewps_pkg::ST_MSQ;
            end
            ewps_pkg::ST_MSQ:  state_next = ewps_pkg::ST_DIFF;
            ewps_pkg::ST_DIFF:
            begin
                root_start = 1'b1;
                state_next = ewps_pkg::ST_ROOT;
            end
            ewps_pkg::ST_ROOT:
            begin
                if (!c_busy && !i_busy)
                    state_next = ewps_pkg::ST_DONE;
            end
            ewps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ewps_pkg::ST_IDLE;
                end
            end
            default: state_next = ewps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewps_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // memories: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == ewps_pkg::ST_RD)
        begin
            cm_rd  <= cm_mem[key_reg];
            csq_rd <= csq_mem[key_reg];
            im_rd  <= im_mem[key_reg];
            isq_rd <= isq_mem[key_reg];
            pm_rd  <= pm_mem[key_reg];
            vm_rd  <= vm_mem[key_reg];
        end
        if (mem_we)
        begin
            cm_mem[key_reg]  <= c_new;
            csq_mem[key_reg] <= csq_new;
            im_mem[key_reg]  <= i_new;
            isq_mem[key_reg] <= isq_new;
            pm_mem[key_reg]  <= p_new;
        end
        if (state_reg == ewps_pkg::ST_CLEAR)
            vm_mem[clr_cnt_reg] <= '0;
        else if (mem_we)
            vm_mem[key_reg] <= v_new;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
            key_reg  <= head_key;
        end
        if (state_reg == ewps_pkg::ST_SQ)
        begin
            csq_reg   <= 64'(item_reg.carrier) * 64'(item_reg.carrier);
            isq_reg   <= 64'(item_reg.interf) * 64'(item_reg.interf);
            v_old_reg <= item_reg.in_range ? vm_rd : '0;
        end
        if (state_reg == ewps_pkg::ST_MUL)
        begin
            cma_reg <= 48'(cm_rd) * 48'(cw);
            cmb_reg <= 48'(item_reg.carrier) * 48'(item_reg.weight);
            ima_reg <= 48'(im_rd) * 48'(cw);
            imb_reg <= 48'(item_reg.interf) * 48'(item_reg.weight);
            pma_reg <= 64'(pm_rd) * 64'(cw);
            pmb_reg <= 64'(item_reg.pathloss) * 64'(item_reg.weight);
            cla_reg <= 48'(csq_rd[31:0]) * 48'(cw);
            clb_reg <= 48'(csq_reg[31:0]) * 48'(item_reg.weight);
            cha_reg <= 48'(csq_rd[63:32]) * 48'(cw);
            chb_reg <= 48'(csq_reg[63:32]) * 48'(item_reg.weight);
            ila_reg <= 48'(isq_rd[31:0]) * 48'(cw);
            ilb_reg <= 48'(isq_reg[31:0]) * 48'(item_reg.weight);
            iha_reg <= 48'(isq_rd[63:32]) * 48'(cw);
            ihb_reg <= 48'(isq_reg[63:32]) * 48'(item_reg.weight);
        end
        if (state_reg == ewps_pkg::ST_SUM)
        begin
            c_new_reg   <= c_new;
            i_new_reg   <= i_new;
            csq_new_reg <= csq_new;
            isq_new_reg <= isq_new;
            p_new_reg   <= p_new;
            v_new_reg   <= v_new;
        end
        if (state_reg == ewps_pkg::ST_MSQ)
        begin
            cmsq_reg <= 64'(c_new_reg) * 64'(c_new_reg);
            imsq_reg <= 64'(i_new_reg) * 64'(i_new_reg);
        end
        if (load_out)
        begin
            avg_carrier        <= v_new_reg.c ? c_new_reg : def_carrier;
            carrier_dev        <= v_new_reg.c ? c_root : def_c_dev;
            carrier_found      <= v_new_reg.c;
            avg_interference   <= v_new_reg.i ? i_new_reg : def_interf;
            interference_dev   <= v_new_reg.i ? i_root : def_i_dev;
            interference_found <= v_new_reg.i;
            avg_pathloss       <= v_new_reg.p ? p_new_reg : def_pathloss;
            pathloss_found     <= v_new_reg.p;
        end
    end

    ewps_isqrt u_c_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (c_diff),
        .busy  (c_busy),
        .root  (c_root)
    );

    ewps_isqrt u_i_root
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (i_diff),
        .busy  (i_busy),
        .root  (i_root)
    );

    assign hold      = (state_reg == ewps_pkg::ST_CLEAR);
    assign out_valid = out_valid_reg;

endmodule

>>> sv/ewma_power_stats_table_unit.sv
// An accepted item is queued, popped in IDLE, then passes RD, SQ, MUL, SUM, MSQ, DIFF, ROOT and DONE.
// The back works on one item at a time; its pace is set by the bit-serial square roots (one bit/cycle).
// Two more items can queue in the front while one is in the back.
// Reset: async, active low; then a clearing pass over all NUM_NODES*NUM_SUB_BANDS
// valid marks (1024 by default), no items accepted meanwhile.
`include "ewma_power_stats_table_unit_defines.svh"
module ewma_power_stats_table_unit
#(
    parameter int NUM_NODES     = ewps_pkg::NUM_NODES_DEF,
    parameter int NUM_SUB_BANDS = ewps_pkg::NUM_SUB_BANDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input item word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [5:0]  node_id,
    input  logic [3:0]  sub_band,
    input  logic        origin_remote,
    input  logic [31:0] carrier_power,
    input  logic [31:0] interference_power,
    input  logic [47:0] pathloss_factor,
    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] avg_carrier,
    output logic [31:0] avg_interference,
    output logic [47:0] avg_pathloss,
    output logic [31:0] carrier_dev,
    output logic [31:0] interference_dev,
    output logic        carrier_found,
    output logic        interference_found,
    output logic        pathloss_found,
    // configuration write word
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int DEPTH = NUM_NODES * NUM_SUB_BANDS;
    localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [16:0] w_local_reg, w_remote_reg;
    logic [31:0] def_carrier_reg, def_interf_reg, def_c_dev_reg, def_i_dev_reg;
    logic [47:0] def_pathloss_reg;

    ewps_pkg::item_t   head_item;
    logic [KW-1:0]     head_key;
    ewps_pkg::q_stat_t q_stat;
    logic              pop, hold;

    // writes are always taken; the user must change config only while the block is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_local_reg      <= 17'd6554;
            w_remote_reg     <= 17'd6554;
            def_carrier_reg  <= '0;
            def_interf_reg   <= '0;
            def_pathloss_reg <= 48'd1;
            def_c_dev_reg    <= '0;
            def_i_dev_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (ewps_pkg::cfg_idx_t'(cfg_index))
                ewps_pkg::CFG_WEIGHT_LOCAL:  w_local_reg      <= cfg_data[16:0];
                ewps_pkg::CFG_WEIGHT_REMOTE: w_remote_reg     <= cfg_data[16:0];
                ewps_pkg::CFG_DEF_CARRIER:   def_carrier_reg  <= cfg_data[31:0];
                ewps_pkg::CFG_DEF_INTERF:    def_interf_reg   <= cfg_data[31:0];
                ewps_pkg::CFG_DEF_PATHLOSS:  def_pathloss_reg <= cfg_data;
                ewps_pkg::CFG_DEF_C_DEV:     def_c_dev_reg    <= cfg_data[31:0];
                ewps_pkg::CFG_DEF_I_DEV:     def_i_dev_reg    <= cfg_data[31:0];
                default:                     ;
            endcase
        end
    end

    // front: decode and queue
    ewps_front #(
        .NUM_NODES     (NUM_NODES),
        .NUM_SUB_BANDS (NUM_SUB_BANDS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .node_id            (node_id),
        .sub_band           (sub_band),
        .origin_remote      (origin_remote),
        .carrier_power      (carrier_power),
        .interference_power (interference_power),
        .pathloss_factor    (pathloss_factor),
        .weight_local       (w_local_reg),
        .weight_remote      (w_remote_reg),
        .hold               (hold),
        .pop                (pop),
        .head_item          (head_item),
        .head_key           (head_key),
        .stat               (q_stat)
    );

    // back: table update, deviations, result register
    ewps_back #(
        .NUM_NODES     (NUM_NODES),
        .NUM_SUB_BANDS (NUM_SUB_BANDS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .stat               (q_stat),
        .head_item          (head_item),
        .head_key           (head_key),
        .pop                (pop),
        .hold               (hold),
        .def_carrier        (def_carrier_reg),
        .def_interf         (def_interf_reg),
        .def_pathloss       (def_pathloss_reg),
        .def_c_dev          (def_c_dev_reg),
        .def_i_dev          (def_i_dev_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .avg_carrier        (avg_carrier),
        .avg_interference   (avg_interference),
        .avg_pathloss       (avg_pathloss),
        .carrier_dev        (carrier_dev),
        .interference_dev   (interference_dev),
        .carrier_found      (carrier_found),
        .interference_found (interference_found),
        .pathloss_found     (pathloss_found)
    );

    // no accepts while the valid marks are being swept
    `EWPS_ASSERT_IMP(a_no_accept_in_clear, hold, !in_ready, "input accepted during clear")
    // an accepted word lands in the queue
    `EWPS_ASSERT_NXT(a_queue_filled, in_valid && in_ready, !q_stat.empty, "accepted word lost")
    // the back only pops a non-empty queue
    `EWPS_ASSERT_IMP(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    // absent carrier returns the configured deviation
    `EWPS_ASSERT_IMP(a_def_c_dev, out_valid && !carrier_found, carrier_dev == def_c_dev_reg,
        "carrier default not applied")

endmodule
